FILE: hw/rtl/strided_copy_plan_generator_assert.svh
// Assertion macros for the strided copy plan generator.
`ifndef STRIDED_COPY_PLAN_GENERATOR_ASSERT_SVH
`define STRIDED_COPY_PLAN_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SCPG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scpg assertion failed");
`define SCPG_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("scpg forbidden condition seen");
`else
`define SCPG_ASSERT(lbl, clk, rstn, prop)
`define SCPG_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: hw/rtl/scpg_pkg.sv
// Shared types and constants of the strided copy plan generator.
`default_nettype none
package scpg_pkg;
  localparam int MAX_DIMS_DEF = 8;
  localparam int IDX_W = 4;
  localparam int CNT_W = IDX_W + 1;
  localparam int ESZ_W = 5;
  localparam logic [ESZ_W-1:0] ESZ_RESET = 5'd1;

  typedef enum logic [3:0] {
    S_LOAD, S_OVLP, S_EMPTY, S_FUSE_SCAN, S_FUSE_WAIT, S_ORD_SCAN, S_ORD_COMMIT,
    S_MUL_S, S_MUL_D, S_MUL_BS, S_MUL_BD, S_DRAIN, S_HDR, S_LVL
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_FUSE, MUL_SIDX, MUL_DIDX, MUL_BS, MUL_BD
  } mul_op_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
    logic             use_order;
    logic [IDX_W-1:0] lvl;
    logic             ov_en;
    logic             fuse_init;
    mul_op_t          mul_op;
    logic             ord_scan;
    logic             ord_clear;
    logic             ord_commit;
    logic             out_empty;
    logic             out_hdr;
    logic             out_lvl;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] levels;
    logic             ov_empty;
    logic             fuse_match;
    logic             fuse_brk;
    logic             found;
    logic             out_free;
  } stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/scpg_dpath.sv
// Datapath: descriptor stores, overlap, fusing, ordering, shared multiplier, output register.
`default_nettype none
`include "strided_copy_plan_generator_assert.svh"
module scpg_dpath #(
  parameter int MAX_DIMS = scpg_pkg::MAX_DIMS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire scpg_pkg::cmd_t              cmd,
  output scpg_pkg::stat_t                  stat,
  input  wire logic                        cfg_we,
  input  wire logic [scpg_pkg::ESZ_W-1:0]  cfg_data,
  input  wire logic [47:0]                 in_src_offset,
  input  wire logic [31:0]                 in_src_extent,
  input  wire logic [31:0]                 in_src_stride,
  input  wire logic [47:0]                 in_dst_offset,
  input  wire logic [31:0]                 in_dst_extent,
  input  wire logic [31:0]                 in_dst_stride,
  input  wire logic                        in_last_dim,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic                             out_kind,
  output logic                             out_nothing_to_copy,
  output logic [3:0]                       out_loop_levels,
  output logic [62:0]                      out_chunk_bytes,
  output logic [63:0]                      out_src_start_bytes,
  output logic [63:0]                      out_dst_start_bytes,
  output logic [31:0]                      out_level_count,
  output logic [63:0]                      out_level_src_step,
  output logic [63:0]                      out_level_dst_step,
  output logic                             out_last
);
  import scpg_pkg::*;

  localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [47:0] soff_r [MAX_DIMS];
  logic [31:0] sext_r [MAX_DIMS];
  logic [31:0] sstr_r [MAX_DIMS];
  logic [47:0] doff_r [MAX_DIMS];
  logic [31:0] dext_r [MAX_DIMS];
  logic [31:0] dstr_r [MAX_DIMS];
  logic [31:0] ov_r   [MAX_DIMS];
  logic [31:0] sdel_r [MAX_DIMS];
  logic [31:0] ddel_r [MAX_DIMS];
  logic [IW-1:0] lo_r [MAX_DIMS];
  logic [63:0] bs_r   [MAX_DIMS];
  logic [63:0] bd_r   [MAX_DIMS];

  logic [ESZ_W-1:0] esz_r;
  logic [CNT_W-1:0] dims_r, n_r, levels_r;
  logic [MAX_DIMS-1:0] fused_r, sel_r;
  logic found_r, brk_r, neg_r, out_valid_r;
  logic [IW-1:0] best_r, tag_idx_r;
  logic [31:0] best_f_r;
  mul_op_t tag_r;
  logic [63:0] prod_r, chunk_r, back_r, sidx_r, didx_r;

  logic wr_ok;
  logic [IW-1:0] rd, wi;
  logic [49:0] s0, d0, s1, d1, x0, x1;
  logic [31:0] ss, ds, abs_s, abs_d, f;
  logic [63:0] ss64, ds64;
  logic ov_empty, fuse_match, cand;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [CNT_W-1:0] lvl_n;
  logic nxt_ok;
  logic [63:0] bsn, bdn;
  logic [63:0] chunk_esz;
  logic out_load;

  function automatic logic [63:0] mul_esz(input logic [63:0] v, input logic [ESZ_W-1:0] e);
    logic [63:0] acc;
    acc = '0;
    for (int b = 0; b < ESZ_W; b++) begin
      if (e[b]) acc = acc + (v << b);
    end
    return acc;
  endfunction

  assign wr_ok    = dims_r < CNT_W'(MAX_DIMS);
  assign wi       = dims_r[IW-1:0];
  assign rd       = cmd.use_order ? lo_r[cmd.lvl[IW-1:0]] : cmd.idx[IW-1:0];
  assign out_load = cmd.out_empty || cmd.out_hdr || cmd.out_lvl;

  always_comb begin
    s0 = {{2{soff_r[rd][47]}}, soff_r[rd]};
    d0 = {{2{doff_r[rd][47]}}, doff_r[rd]};
    s1 = s0 + {18'b0, sext_r[rd]};
    d1 = d0 + {18'b0, dext_r[rd]};
    x0 = ($signed(s0) < $signed(d0)) ? d0 : s0;
    x1 = ($signed(s1) < $signed(d1)) ? s1 : d1;
    ov_empty = $signed(x1) < $signed(x0);
    ss = sstr_r[rd];
    ds = dstr_r[rd];
    ss64 = {{32{ss[31]}}, ss};
    ds64 = {{32{ds[31]}}, ds};
    abs_s = ss[31] ? (~ss + 32'd1) : ss;
    abs_d = ds[31] ? (~ds + 32'd1) : ds;
    f = (abs_s < abs_d) ? abs_s : abs_d;
    fuse_match = !fused_r[rd] && (ss == ds) && (chunk_r == {32'b0, abs_s});
    cand = !sel_r[rd] && (!found_r || (best_f_r < f));
    lvl_n = {1'b0, cmd.lvl} + 1'b1;
    nxt_ok = lvl_n < levels_r;
    bsn = nxt_ok ? bs_r[lvl_n[IW-1:0]] : '0;
    bdn = nxt_ok ? bd_r[lvl_n[IW-1:0]] : '0;
    chunk_esz = mul_esz(chunk_r, esz_r);
  end

  always_comb begin
    ma = {1'b0, ov_r[rd]};
    mb = {ss[31], ss};
    case (cmd.mul_op)
      MUL_FUSE: begin
        ma = {1'b0, chunk_r[31:0]};
        mb = {1'b0, ov_r[rd]};
      end
      MUL_SIDX: begin
        ma = {1'b0, sdel_r[rd]};
        mb = {ss[31], ss};
      end
      MUL_DIDX: begin
        ma = {1'b0, ddel_r[rd]};
        mb = {ds[31], ds};
      end
      MUL_BS: begin
        ma = {1'b0, ov_r[rd]};
        mb = {ss[31], ss};
      end
      MUL_BD: begin
        ma = {1'b0, ov_r[rd]};
        mb = {ds[31], ds};
      end
      default: begin
        ma = {1'b0, ov_r[rd]};
        mb = {ss[31], ss};
      end
    endcase
    mp = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esz_r       <= ESZ_RESET;
      dims_r      <= '0;
      n_r         <= '0;
      levels_r    <= '0;
      fused_r     <= '0;
      sel_r       <= '0;
      found_r     <= 1'b0;
      tag_r       <= MUL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) esz_r <= cfg_data;
      if (cmd.load) begin
        if (in_last_dim) begin
          n_r    <= dims_r + CNT_W'(wr_ok);
          dims_r <= '0;
        end else if (wr_ok) begin
          dims_r <= dims_r + 1'b1;
        end
      end
      if (cmd.fuse_init) begin
        fused_r  <= '0;
        sel_r    <= '0;
        levels_r <= '0;
      end
      if (cmd.mul_op == MUL_FUSE) begin
        fused_r[rd] <= 1'b1;
        sel_r[rd]   <= 1'b1;
      end
      if (cmd.ord_clear || cmd.ord_commit) begin
        found_r <= 1'b0;
      end else if (cmd.ord_scan && cand) begin
        found_r <= 1'b1;
      end
      if (cmd.ord_commit) begin
        sel_r[best_r] <= 1'b1;
        levels_r      <= levels_r + 1'b1;
      end
      tag_r <= cmd.mul_op;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      soff_r[wi] <= in_src_offset;
      sext_r[wi] <= in_src_extent;
      sstr_r[wi] <= in_src_stride;
      doff_r[wi] <= in_dst_offset;
      dext_r[wi] <= in_dst_extent;
      dstr_r[wi] <= in_dst_stride;
    end
    if (cmd.ov_en) begin
      ov_r[rd]   <= 32'(x1 - x0);
      sdel_r[rd] <= 32'(x0 - s0);
      ddel_r[rd] <= 32'(x0 - d0);
    end
    if (cmd.fuse_init) begin
      chunk_r <= 64'd1;
      back_r  <= '0;
      sidx_r  <= '0;
      didx_r  <= '0;
    end
    if (cmd.mul_op == MUL_FUSE) begin
      brk_r <= (ov_r[rd] != sext_r[rd]) || (ov_r[rd] != dext_r[rd]);
      neg_r <= ss[31];
    end
    if (cmd.ord_scan && cand) begin
      best_r   <= rd;
      best_f_r <= f;
    end
    if (cmd.ord_commit) lo_r[levels_r[IW-1:0]] <= best_r;
    prod_r    <= mp[63:0];
    tag_idx_r <= cmd.lvl[IW-1:0];
    case (tag_r)
      MUL_FUSE: begin
        chunk_r <= prod_r;
        if (neg_r) back_r <= back_r + prod_r - chunk_r;
      end
      MUL_SIDX: sidx_r <= sidx_r + prod_r;
      MUL_DIDX: didx_r <= didx_r + prod_r;
      MUL_BS:   bs_r[tag_idx_r] <= prod_r;
      MUL_BD:   bd_r[tag_idx_r] <= prod_r;
      default: ;
    endcase
    if (cmd.out_empty) begin
      out_kind            <= 1'b0;
      out_nothing_to_copy <= 1'b1;
      out_loop_levels     <= '0;
      out_chunk_bytes     <= '0;
      out_src_start_bytes <= '0;
      out_dst_start_bytes <= '0;
      out_level_count     <= '0;
      out_level_src_step  <= '0;
      out_level_dst_step  <= '0;
      out_last            <= 1'b1;
    end
    if (cmd.out_hdr) begin
      out_kind            <= 1'b0;
      out_nothing_to_copy <= 1'b0;
      out_loop_levels     <= levels_r[3:0];
      out_chunk_bytes     <= chunk_esz[62:0];
      out_src_start_bytes <= mul_esz(sidx_r - back_r, esz_r);
      out_dst_start_bytes <= mul_esz(didx_r - back_r, esz_r);
      out_level_count     <= '0;
      out_level_src_step  <= '0;
      out_level_dst_step  <= '0;
      out_last            <= (levels_r == '0);
    end
    if (cmd.out_lvl) begin
      out_kind            <= 1'b1;
      out_nothing_to_copy <= 1'b0;
      out_loop_levels     <= '0;
      out_chunk_bytes     <= '0;
      out_src_start_bytes <= '0;
      out_dst_start_bytes <= '0;
      out_level_count     <= ov_r[rd];
      out_level_src_step  <= mul_esz(ss64 - bsn, esz_r);
      out_level_dst_step  <= mul_esz(ds64 - bdn, esz_r);
      out_last            <= !nxt_ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.n          = n_r;
  assign stat.levels     = levels_r;
  assign stat.ov_empty   = ov_empty;
  assign stat.fuse_match = fuse_match;
  assign stat.fuse_brk   = brk_r;
  assign stat.found      = found_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  `SCPG_NEVER(a_out_overwrite, clk, rst_n, out_load && out_valid_r && out_stall)
  `SCPG_ASSERT(a_levels_le_n, clk, rst_n, !cmd.ord_commit || (levels_r < n_r))
  `SCPG_NEVER(a_fused_selected, clk, rst_n, (fused_r & ~sel_r) != '0)
endmodule
`default_nettype wire

FILE: hw/rtl/scpg_ctrl.sv
// Controller state machine that sequences loading, planning and emission.
`default_nettype none
module scpg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last_dim,
  output logic                 in_stall,
  input  wire scpg_pkg::stat_t stat,
  output scpg_pkg::cmd_t       cmd
);
  import scpg_pkg::*;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] n_m1, lv_m1;
  logic last_i, last_j;

  assign n_m1   = stat.n - 1'b1;
  assign lv_m1  = stat.levels - 1'b1;
  assign last_i = {1'b0, i_r} == n_m1;
  assign last_j = {1'b0, j_r} == lv_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_last_dim) begin
          state_nxt = S_OVLP;
          i_nxt     = '0;
        end
      end
      S_OVLP: begin
        if (stat.ov_empty) begin
          state_nxt = S_EMPTY;
        end else if (last_i) begin
          state_nxt = S_FUSE_SCAN;
          i_nxt     = n_m1[IDX_W-1:0];
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) state_nxt = S_LOAD;
      end
      S_FUSE_SCAN: begin
        if (stat.fuse_match) begin
          state_nxt = S_FUSE_WAIT;
        end else if (i_r == '0) begin
          state_nxt = S_ORD_SCAN;
        end else begin
          i_nxt = i_r - 1'b1;
        end
      end
      S_FUSE_WAIT: begin
        if (stat.fuse_brk) begin
          state_nxt = S_ORD_SCAN;
          i_nxt     = '0;
        end else begin
          state_nxt = S_FUSE_SCAN;
          i_nxt     = n_m1[IDX_W-1:0];
        end
      end
      S_ORD_SCAN: begin
        if (last_i) state_nxt = S_ORD_COMMIT;
        else i_nxt = i_r + 1'b1;
      end
      S_ORD_COMMIT: begin
        state_nxt = stat.found ? S_ORD_SCAN : S_MUL_S;
        i_nxt     = '0;
      end
      S_MUL_S: state_nxt = S_MUL_D;
      S_MUL_D: begin
        if (last_i) begin
          state_nxt = (stat.levels == '0) ? S_DRAIN : S_MUL_BS;
          j_nxt     = '0;
        end else begin
          state_nxt = S_MUL_S;
          i_nxt     = i_r + 1'b1;
        end
      end
      S_MUL_BS: state_nxt = S_MUL_BD;
      S_MUL_BD: begin
        if (last_j) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_MUL_BS;
          j_nxt     = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_HDR;
        j_nxt     = '0;
      end
      S_HDR: begin
        if (stat.out_free) state_nxt = (stat.levels == '0) ? S_LOAD : S_LVL;
      end
      S_LVL: begin
        if (stat.out_free) begin
          if (last_j) state_nxt = S_LOAD;
          else j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    cmd.idx    = i_r;
    cmd.lvl    = j_r;
    in_stall   = 1'b1;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_OVLP: begin
        cmd.ov_en     = 1'b1;
        cmd.fuse_init = last_i && !stat.ov_empty;
      end
      S_EMPTY:      cmd.out_empty = stat.out_free;
      S_FUSE_SCAN: begin
        if (stat.fuse_match) cmd.mul_op = MUL_FUSE;
        cmd.ord_clear = !stat.fuse_match && (i_r == '0);
      end
      S_FUSE_WAIT:  cmd.ord_clear = stat.fuse_brk;
      S_ORD_SCAN:   cmd.ord_scan = 1'b1;
      S_ORD_COMMIT: cmd.ord_commit = stat.found;
      S_MUL_S:      cmd.mul_op = MUL_SIDX;
      S_MUL_D:      cmd.mul_op = MUL_DIDX;
      S_MUL_BS: begin
        cmd.use_order = 1'b1;
        cmd.mul_op    = MUL_BS;
      end
      S_MUL_BD: begin
        cmd.use_order = 1'b1;
        cmd.mul_op    = MUL_BD;
      end
      S_DRAIN: ;
      S_HDR:        cmd.out_hdr = stat.out_free;
      S_LVL: begin
        cmd.use_order = 1'b1;
        cmd.out_lvl   = stat.out_free;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/strided_copy_plan_generator.sv
// Top level of the strided copy plan generator.
//
//  channel | handshake          | carries
//  in_     | in_valid/in_stall  | one dimension descriptor per request
//  out_    | out_valid/out_stall| header request, then one request per loop level
//  cfg_    | cfg_valid/cfg_ready| element_bytes register write
//
// A descriptor without last_dim is only stored. A closing descriptor starts planning,
// paced by the single-read descriptor store and the shared 32x32 multiplier, and then
// emission of the plan; in_stall stays high until the plan has been emitted.
// Reset is synchronous, active low, and clears all control state; no clearing pass.
// A stalled output holds its request; planning waits only where a result must be loaded.
`default_nettype none
module strided_copy_plan_generator #(
  parameter int MAX_DIMS = scpg_pkg::MAX_DIMS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [47:0]         in_src_offset,
  input  wire logic        [31:0]         in_src_extent,
  input  wire logic signed [31:0]         in_src_stride,
  input  wire logic signed [47:0]         in_dst_offset,
  input  wire logic        [31:0]         in_dst_extent,
  input  wire logic signed [31:0]         in_dst_stride,
  input  wire logic                       in_last_dim,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_kind,
  output logic                            out_nothing_to_copy,
  output logic        [3:0]               out_loop_levels,
  output logic        [62:0]              out_chunk_bytes,
  output logic signed [63:0]              out_src_start_bytes,
  output logic signed [63:0]              out_dst_start_bytes,
  output logic        [31:0]              out_level_count,
  output logic signed [63:0]              out_level_src_step,
  output logic signed [63:0]              out_level_dst_step,
  output logic                            out_last,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [scpg_pkg::ESZ_W-1:0] cfg_element_bytes
);
  import scpg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  scpg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_dim (in_last_dim),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  scpg_dpath #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_data            (cfg_element_bytes),
    .in_src_offset       (in_src_offset),
    .in_src_extent       (in_src_extent),
    .in_src_stride       (in_src_stride),
    .in_dst_offset       (in_dst_offset),
    .in_dst_extent       (in_dst_extent),
    .in_dst_stride       (in_dst_stride),
    .in_last_dim         (in_last_dim),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_nothing_to_copy (out_nothing_to_copy),
    .out_loop_levels     (out_loop_levels),
    .out_chunk_bytes     (out_chunk_bytes),
    .out_src_start_bytes (out_src_start_bytes),
    .out_dst_start_bytes (out_dst_start_bytes),
    .out_level_count     (out_level_count),
    .out_level_src_step  (out_level_src_step),
    .out_level_dst_step  (out_level_dst_step),
    .out_last            (out_last)
  );
endmodule
`default_nettype wire

FILE: tb/sv/strided_copy_plan_generator_test.sv
// Self-checking testbench for the strided copy plan generator.
`timescale 1ns / 100ps
`default_nettype none
module strided_copy_plan_generator_test;
  import scpg_pkg::*;

  localparam int NDIM = MAX_DIMS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int LATENCY = 400;

  typedef struct packed {
    logic signed [47:0] src_offset;
    logic [31:0] src_extent;
    logic signed [31:0] src_stride;
    logic signed [47:0] dst_offset;
    logic [31:0] dst_extent;
    logic signed [31:0] dst_stride;
    logic last_dim;
  } desc_t;

  typedef struct packed {
    logic kind;
    logic nothing_to_copy;
    logic [3:0] loop_levels;
    logic [62:0] chunk_bytes;
    logic [63:0] src_start_bytes;
    logic [63:0] dst_start_bytes;
    logic [31:0] level_count;
    logic [63:0] level_src_step;
    logic [63:0] level_dst_step;
    logic last;
  } plan_t;

  typedef struct {
    desc_t d;
    bit has_plan;
    plan_t plan;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  desc_t req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  plan_t got;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ESZ_W-1:0] cfg_element_bytes = ESZ_RESET;

  plan_t plan_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int gap_len = 0;

  logic [4:0] esz_reg;
  desc_t held[NDIM];
  int held_cnt;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  strided_copy_plan_generator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_src_offset(req.src_offset), .in_src_extent(req.src_extent),
    .in_src_stride(req.src_stride), .in_dst_offset(req.dst_offset),
    .in_dst_extent(req.dst_extent), .in_dst_stride(req.dst_stride),
    .in_last_dim(req.last_dim),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(got.kind), .out_nothing_to_copy(got.nothing_to_copy),
    .out_loop_levels(got.loop_levels), .out_chunk_bytes(got.chunk_bytes),
    .out_src_start_bytes(got.src_start_bytes), .out_dst_start_bytes(got.dst_start_bytes),
    .out_level_count(got.level_count), .out_level_src_step(got.level_src_step),
    .out_level_dst_step(got.level_dst_step), .out_last(got.last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_element_bytes(cfg_element_bytes)
  );

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Compute the plan for one request; pushes results when the set closes.
  function automatic void plan_request(desc_t d);
    logic [63:0] ov_off[NDIM], ov_size[NDIM], ss[NDIM], ds[NDIM];
    logic [63:0] s0, d0, s1, d1, x0, x1, chunk, back, sidx, didx, jump, f, a, b;
    logic [63:0] st_s[NDIM], st_d[NDIM];
    logic [7:0] fused;
    bit sel[NDIM];
    int order[NDIM];
    int n, levels, cur, best, dd;
    plan_t p;
    if (held_cnt < NDIM) begin
      held[held_cnt] = d;
      held_cnt++;
    end
    if (!d.last_dim) return;
    n = held_cnt;
    held_cnt = 0;
    p = '0;
    for (int i = 0; i < n; i++) begin
      s0 = 64'(held[i].src_offset);
      d0 = 64'(held[i].dst_offset);
      s1 = s0 + 64'(held[i].src_extent);
      d1 = d0 + 64'(held[i].dst_extent);
      x0 = ($signed(s0) < $signed(d0)) ? d0 : s0;
      x1 = ($signed(s1) < $signed(d1)) ? s1 : d1;
      if ($signed(x1) < $signed(x0)) begin
        p.nothing_to_copy = 1'b1;
        p.last = 1'b1;
        plan_q.push_back(p);
        return;
      end
      ov_off[i] = x0;
      ov_size[i] = x1 - x0;
      ss[i] = 64'(held[i].src_stride);
      ds[i] = 64'(held[i].dst_stride);
      sel[i] = 0;
    end
    chunk = 1;
    back = 0;
    fused = '0;
    forever begin
      cur = -1;
      for (int k = n - 1; k >= 0; k--)
        if (cur < 0 && !fused[k] && ss[k] == ds[k] && mag(ss[k]) == chunk) cur = k;
      if (cur < 0) break;
      fused[cur] = 1'b1;
      sel[cur] = 1;
      if (ss[cur][63]) back += chunk * (ov_size[cur] - 1);
      chunk *= ov_size[cur];
      if (ov_size[cur] != 64'(held[cur].src_extent) ||
          ov_size[cur] != 64'(held[cur].dst_extent)) break;
    end
    levels = 0;
    forever begin
      best = -1;
      jump = 0;
      for (int i = 0; i < n; i++) begin
        if (!sel[i]) begin
          a = mag(ss[i]);
          b = mag(ds[i]);
          f = a < b ? a : b;
          if (best < 0 || jump < f) begin
            best = i;
            jump = f;
          end
        end
      end
      if (best < 0) break;
      sel[best] = 1;
      order[levels++] = best;
    end
    for (int i = 0; i < levels; i++) begin
      dd = order[i];
      st_s[i] = ss[dd] * 64'(esz_reg);
      st_d[i] = ds[dd] * 64'(esz_reg);
      if (i > 0) begin
        st_s[i-1] -= ov_size[dd] * st_s[i];
        st_d[i-1] -= ov_size[dd] * st_d[i];
      end
    end
    sidx = 0;
    didx = 0;
    for (int i = 0; i < n; i++) begin
      sidx += (ov_off[i] - 64'(held[i].src_offset)) * ss[i];
      didx += (ov_off[i] - 64'(held[i].dst_offset)) * ds[i];
    end
    p.loop_levels = 4'(levels);
    p.chunk_bytes = 63'(chunk * 64'(esz_reg));
    p.src_start_bytes = (sidx - back) * 64'(esz_reg);
    p.dst_start_bytes = (didx - back) * 64'(esz_reg);
    p.last = (levels == 0);
    plan_q.push_back(p);
    for (int i = 0; i < levels; i++) begin
      p = '0;
      p.kind = 1'b1;
      p.level_count = ov_size[order[i]][31:0];
      p.level_src_step = st_s[i];
      p.level_dst_step = st_d[i];
      p.last = (i + 1 == levels);
      plan_q.push_back(p);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] e, logic [63:0] g);
    $display("mismatch %s: expected %h got %h at %0t", what, e, g, $realtime);
    errors++;
  endtask

  // Check results and randomize output stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (plan_q.size() == 0) begin
        report_mismatch("unexpected request", 0, 0);
      end else begin
        plan_t e;
        e = plan_q.pop_front();
        if (e.kind != got.kind) report_mismatch("kind", e.kind, got.kind);
        if (e.nothing_to_copy != got.nothing_to_copy)
          report_mismatch("nothing_to_copy", e.nothing_to_copy, got.nothing_to_copy);
        if (e.loop_levels != got.loop_levels)
          report_mismatch("loop_levels", e.loop_levels, got.loop_levels);
        if (e.chunk_bytes != got.chunk_bytes)
          report_mismatch("chunk_bytes", e.chunk_bytes, got.chunk_bytes);
        if (e.src_start_bytes != got.src_start_bytes)
          report_mismatch("src_start_bytes", e.src_start_bytes, got.src_start_bytes);
        if (e.dst_start_bytes != got.dst_start_bytes)
          report_mismatch("dst_start_bytes", e.dst_start_bytes, got.dst_start_bytes);
        if (e.level_count != got.level_count)
          report_mismatch("level_count", e.level_count, got.level_count);
        if (e.level_src_step != got.level_src_step)
          report_mismatch("level_src_step", e.level_src_step, got.level_src_step);
        if (e.level_dst_step != got.level_dst_step)
          report_mismatch("level_dst_step", e.level_dst_step, got.level_dst_step);
        if (e.last != got.last) report_mismatch("last", e.last, got.last);
      end
    end
    if (gap_len > 0) begin
      out_stall <= 1'b1;
      gap_len <= gap_len - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      gap_len <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Stop when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send(desc_t d);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plan_request(d);
  endtask

  task automatic set_element_bytes(logic [4:0] v);
    in_valid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_element_bytes <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    esz_reg = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_stride();
    case ($urandom_range(0, 5))
      0: return 32'sd1;
      1: return -32'sd1;
      2: return $signed(32'($urandom_range(1, 64)));
      3: return -$signed(32'($urandom_range(1, 64)));
      4: return $signed($urandom());
      default: return $signed(32'($urandom_range(0, 3) == 0 ? 0 : 4));
    endcase
  endfunction

  function automatic desc_t rand_desc(bit last);
    desc_t d;
    logic [47:0] base;
    base = $urandom_range(0, 3) == 0 ? 48'({$urandom(), $urandom()}) :
                                       48'($urandom_range(0, 40));
    d.src_offset = $signed(base) + $signed(48'($urandom_range(0, 8)));
    d.dst_offset = $signed(base) + $signed(48'($urandom_range(0, 8)));
    d.src_extent = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(1, 24);
    d.dst_extent = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(1, 24);
    if ($urandom_range(0, 15) == 0) d.dst_offset = 48'({$urandom(), $urandom()});
    d.src_stride = rand_stride();
    d.dst_stride = ($urandom_range(0, 2) != 0) ? d.src_stride : rand_stride();
    d.last_dim = last;
    return d;
  endfunction

  row_t rows[$];

  function automatic desc_t mk(logic [47:0] so, logic [31:0] se, logic [31:0] sst,
                               logic [47:0] dof, logic [31:0] de, logic [31:0] dst,
                               bit last);
    desc_t d;
    d = '{so, se, sst, dof, de, dst, last};
    return d;
  endfunction

  initial begin
    plan_t p;
    int dims;
    logic [4:0] esz_set[5];
    esz_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4};
    esz_reg = ESZ_RESET;
    held_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty overlap, headers known up front.
    p = '0;
    p.nothing_to_copy = 1'b1;
    p.last = 1'b1;
    rows.push_back('{mk(48'd10, 32'd0, 32'd1, 48'd20, 32'd0, 32'd1, 1), 1, p});
    rows.push_back('{mk(48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                        48'h8000_0000_0000, 32'd1, 32'h7FFF_FFFF, 1), 1, p});
    // Single contiguous dimension: chunk equals extent.
    p = '0;
    p.chunk_bytes = 63'd5;
    p.last = 1'b1;
    rows.push_back('{mk(48'd0, 32'd5, 32'd1, 48'd0, 32'd5, 32'd1, 1), 1, p});
    // Negative stride, extremes, multi-dim and overflow of the store.
    rows.push_back('{mk(48'd3, 32'd8, 32'hFFFF_FFFF, 48'd0, 32'd9, 32'hFFFF_FFFF, 1), 0, p});
    rows.push_back('{mk(48'd0, 32'd4, 32'd6, 48'd1, 32'd6, 32'd6, 0), 0, p});
    rows.push_back('{mk(48'd0, 32'd6, 32'd1, 48'd0, 32'd6, 32'd1, 1), 0, p});
    rows.push_back('{mk(48'h8000_0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        48'h8000_0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1), 0, p});
    for (int i = 0; i < 10; i++)
      rows.push_back('{mk(48'(i), 32'd3, 32'(3 - i), 48'(i), 32'd4, 32'(i + 1),
                          i == 9), 0, p});
    rows.push_back('{mk(48'd2, 32'd7, 32'd0, 48'd0, 32'd7, 32'd0, 1), 0, p});

    foreach (rows[i]) begin
      send(rows[i].d);
      if (rows[i].has_plan && plan_q.size() > 0) plan_q[plan_q.size() - 1] = rows[i].plan;
    end

    for (int ph = 0; ph < 5; ph++) begin
      set_element_bytes(esz_set[ph]);
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(0, 9) == 0) dims = $urandom_range(9, 11);
        else dims = $urandom_range(1, 4);
        for (int j = 0; j < dims; j++) send(rand_desc(j == dims - 1));
      end
    end

    in_valid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
